/* src/word_length_histogram_top_macros.svh */
`ifndef WORD_LENGTH_HISTOGRAM_TOP_MACROS_SVH
`define WORD_LENGTH_HISTOGRAM_TOP_MACROS_SVH

// Plain concurrent check on clk_i, off while rst_ni is low.
`define WLH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled word stays valid and unchanged.
`define WLH_ASSERT_HOLD(lbl, vld, stl, pay, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && stl) |=> (vld && $stable(pay))) else $error(msg);

`endif

/* src/wlh_pkg.sv */
`default_nettype none

package wlh_pkg;

  localparam int CNT_W     = 32;
  localparam int SCALE_W   = 8;
  localparam int BIN_IDX_W = 4;
  localparam int PROD_W    = CNT_W + SCALE_W;
  localparam int QUOT_W    = 8;
  localparam int STEP_W    = $clog2(QUOT_W);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [SCALE_W-1:0] BAR_SCALE_RST = 8'd15;
  localparam logic [0:0]         REG_BAR_SCALE = 1'b0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic {
    OP_TEXT   = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] text_byte;
  } in_word_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [CNT_W-1:0]     bin_count;
    logic [SCALE_W-1:0]   bar_length;
    logic [CNT_W-1:0]     overflow_words;
    logic                 last_bin;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* src/wlh_ram.sv */
`default_nettype none

module wlh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/wlh_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. Expects dividend/divisor < 2**QUOT_W.
module wlh_div
  import wlh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] sh_q, sh_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, sh_q[QUOT_W-1]};
  assign ge    = trial >= {1'b0, req_i.divisor};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.dividend[PROD_W-1:QUOT_W];
      sh_d   = req_i.dividend[QUOT_W-1:0];
      step_d = STEP_W'(QUOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? CNT_W'(trial - {1'b0, req_i.divisor}) : trial[CNT_W-1:0];
      sh_d   = {sh_q[QUOT_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      sh_q   <= sh_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule

`default_nettype wire

/* src/word_length_histogram_top.sv */
`default_nettype none

// Word length histogram. Text words (op = text) carry one byte each; space,
// tab and newline end a word, any other byte extends it. A closed word of
// length below NUM_BINS bumps that bin, longer words bump the overflow
// counter; all counters saturate at all ones. A report word (op = report)
// closes any pending word, then emits NUM_BINS result words, bin 0 first,
// each with its count, the shared overflow count, and a bar length of
// count * bar_scale / peak (floor, at least 1 for a nonzero count), with
// last_bin set on the final one. The report then clears all counts;
// bar_scale (APB offset 0x0, reset 15) is kept.
// Flow: a text byte that extends a word, hits a separator outside a word,
// or closes a word into overflow is handled in the idle state alone; one
// that closes a word into a bin also passes the update state (bin read,
// then increment and write back through the bin RAM). A report is
// accepted, passes the update state if it closes a word into a bin, then
// runs the peak scan (read and compare per bin), then per bin: read,
// multiply, divider start, the eight divider steps and done flag, then
// output, held while the sink stalls. Bin clearing is done through per-bin
// valid flops, so there is no clearing pass after reset or after a report.
module word_length_histogram_top
  import wlh_pkg::*;
#(
  parameter int NUM_BINS = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input words
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_word_t          in_word_i,
  // result words
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_word_t              out_word_o,
  // APB config
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int IW = $clog2(NUM_BINS);     // bin address
  localparam int LW = $clog2(NUM_BINS + 1); // length, saturates at NUM_BINS

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,      // write back incremented bin
    ST_PK_RD,
    ST_PK_CMP,
    ST_BN_RD,
    ST_BN_MUL,
    ST_BN_START,
    ST_BN_DIV,
    ST_BN_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [LW-1:0]      len_q, len_d;
  logic [CNT_W-1:0]   ovf_q, ovf_d;
  logic [NUM_BINS-1:0] vld_q, vld_d;       // bin holds a written count
  logic               vld_rd_q, vld_rd_d;  // valid flag of the last read
  logic [IW-1:0]      upd_addr_q, upd_addr_d;
  logic               rpt_q, rpt_d;        // report pending after the update
  logic [IW-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]   peak_q, peak_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [CNT_W-1:0]   ram_wdata, ram_rdata;
  logic [CNT_W-1:0]   rd_val;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_acc, is_sep, len_nz, len_bin, cfg_we, last_idx;
  logic [SCALE_W-1:0] bar;

  wlh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign div_req.start    = (state_q == ST_BN_START);
  assign div_req.dividend = prod_q;
  assign div_req.divisor  = peak_q;

  wlh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // unwritten bins read as zero
  assign rd_val = vld_rd_q ? ram_rdata : '0;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_sep     = (in_word_i.text_byte == CH_SPACE) || (in_word_i.text_byte == CH_TAB) ||
                      (in_word_i.text_byte == CH_NL);
  assign len_nz     = (len_q != '0);
  assign len_bin    = len_nz && (len_q < LW'(NUM_BINS));
  assign last_idx   = (idx_q == IW'(NUM_BINS - 1));

  // nonzero count always gets a bar of at least one
  assign bar = (cnt_q == '0) ? '0 :
               (div_rsp.quot == '0) ? SCALE_W'(1) : div_rsp.quot;

  // APB: always ready, one register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_BAR_SCALE);
  assign prdata = (paddr[ADDR_W-1:2] == REG_BAR_SCALE) ? DATA_W'(scale_q) : '0;

  always_comb begin
    state_d     = state_q;
    scale_d     = cfg_we ? pwdata[SCALE_W-1:0] : scale_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    vld_d       = vld_q;
    vld_rd_d    = vld_rd_q;
    upd_addr_d  = upd_addr_q;
    rpt_d       = rpt_q;
    idx_d       = idx_q;
    peak_d      = peak_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = upd_addr_q;
    ram_wdata   = sat_inc(rd_val);
    ram_re      = 1'b0;
    ram_raddr   = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word_i.op == OP_TEXT && !is_sep) begin
            if (len_q < LW'(NUM_BINS)) begin
              len_d = len_q + LW'(1);
            end
          end else begin
            // word ends here (separator or report)
            len_d      = '0;
            rpt_d      = (in_word_i.op == OP_REPORT);
            idx_d      = '0;
            peak_d     = '0;
            upd_addr_d = IW'(len_q);
            if (len_bin) begin
              ram_re    = 1'b1;
              ram_raddr = IW'(len_q);
              vld_rd_d  = vld_q[IW'(len_q)];
              state_d   = ST_UPD;
            end else begin
              if (len_nz) begin
                ovf_d = sat_inc(ovf_q);
              end
              if (in_word_i.op == OP_REPORT) begin
                state_d = ST_PK_RD;
              end
            end
          end
        end
      end

      ST_UPD: begin
        ram_we             = 1'b1;
        vld_d[upd_addr_q]  = 1'b1;
        state_d            = rpt_q ? ST_PK_RD : ST_IDLE;
      end

      ST_PK_RD: begin
        ram_re   = 1'b1;
        vld_rd_d = vld_q[idx_q];
        state_d  = ST_PK_CMP;
      end

      ST_PK_CMP: begin
        if (rd_val > peak_q) begin
          peak_d = rd_val;
        end
        if (last_idx) begin
          idx_d   = '0;
          state_d = ST_BN_RD;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_PK_RD;
        end
      end

      ST_BN_RD: begin
        ram_re   = 1'b1;
        vld_rd_d = vld_q[idx_q];
        state_d  = ST_BN_MUL;
      end

      ST_BN_MUL: begin
        cnt_d   = rd_val;
        prod_d  = PROD_W'(rd_val) * PROD_W'(scale_q);
        state_d = ST_BN_START;
      end

      ST_BN_START: begin
        state_d = ST_BN_DIV;
      end

      ST_BN_DIV: begin
        if (div_rsp.done) begin
          out_d.bin_index      = BIN_IDX_W'(idx_q);
          out_d.bin_count      = cnt_q;
          out_d.bar_length     = bar;
          out_d.overflow_words = ovf_q;
          out_d.last_bin       = last_idx;
          out_valid_d          = 1'b1;
          state_d              = ST_BN_OUT;
        end
      end

      ST_BN_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (last_idx) begin
            // report done: clear the store
            vld_d   = '0;
            ovf_d   = '0;
            rpt_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = ST_BN_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_q     <= BAR_SCALE_RST;
      len_q       <= '0;
      ovf_q       <= '0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      upd_addr_q  <= '0;
      rpt_q       <= 1'b0;
      idx_q       <= '0;
      peak_q      <= '0;
      cnt_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      scale_q     <= scale_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      vld_q       <= vld_d;
      vld_rd_q    <= vld_rd_d;
      upd_addr_q  <= upd_addr_d;
      rpt_q       <= rpt_d;
      idx_q       <= idx_d;
      peak_q      <= peak_d;
      cnt_q       <= cnt_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

/* src/wlh_checker.sv */
`default_nettype none

`include "word_length_histogram_top_macros.svh"

module wlh_checker
  import wlh_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_word_t  in_word_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  `WLH_ASSERT_HOLD(a_out_hold, out_valid_o, out_stall_i, out_word_o, "result word changed under stall")

  // no input is taken while a report is being delivered
  `WLH_ASSERT(a_busy_in_report, out_valid_o |-> in_stall_o, "input open during report")

  `WLH_ASSERT(a_report_stalls, (in_valid_i && !in_stall_o && in_word_i.op == OP_REPORT) |=> in_stall_o, "report word did not stall input")

  `WLH_ASSERT(a_bar_nonzero, out_valid_o |-> ((out_word_o.bin_count == 32'd0) == (out_word_o.bar_length == 8'd0)), "bar length disagrees with count")

  `WLH_ASSERT(a_last_ends, (out_valid_o && !out_stall_i && out_word_o.last_bin) |=> !out_valid_o, "result after last bin")

endmodule

bind word_length_histogram_top wlh_checker u_checker (.*);

`default_nettype wire
